### design/dss_pkg.sv
// ----------------------------------------------------------------------------
// Deduplicating set store package
// Capacity, derived widths, operation codes and the transfer and control
// types shared by the set store modules.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int VALUE_W = 64;
	localparam int COUNT_OUT_W = 5;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_CONTAINS = 2'd1;
	localparam logic [1:0] FUNC_POP = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [VALUE_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic found;
		logic stored;
		logic full_refused;
		logic popped_valid;
		logic [VALUE_W-1:0] popped_value;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic is_empty;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic [CNT_W-1:0] limit;
		logic [VALUE_W-1:0] key;
	} scan_cmd_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_stat_t;

endpackage

### design/dedup_set_store.sv
// ----------------------------------------------------------------------------
// Deduplicating set store
// Holds up to CAPACITY distinct 64-bit values with add, contains and pop of
// the newest entry; one result per request.
// ----------------------------------------------------------------------------
// An add or contains request searches the entries in use one per cycle
// through the single read port of the entry store. A pop reads the newest
// entry, and a pop of an empty set or an unused code finishes without a
// read. Only one request is in work at a time; the finished result waits
// in an output register so that the next request is taken while it does.
module dedup_set_store
	import dss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_POPRD,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [1:0]         func_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_inc;
	logic [CNT_W-1:0]   count_m1;
	rsp_t               res_q;
	rsp_t               res_d;
	rsp_t               rsp_q;
	logic               rsp_valid_q;
	logic               rsp_load;
	logic               accept;
	logic               full;
	scan_cmd_t          scan_cmd;
	scan_stat_t         scan_stat;
	logic [ADDR_W-1:0]  scan_raddr;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	assign req_ready = (state_q == S_IDLE);
	assign accept = req_valid && req_ready;
	assign count_inc = count_q + CNT_W'(1);
	assign count_m1 = count_q - CNT_W'(1);
	assign full = (count_q == CNT_W'(CAPACITY));
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	assign scan_cmd = '{
		start: accept && ((req.func == FUNC_ADD) || (req.func == FUNC_CONTAINS)),
		limit: count_q,
		key: req.item_value
	};

	assign ram_we = (state_q == S_SCAN) && scan_stat.done && !scan_stat.hit &&
		(func_q == FUNC_ADD) && !full;
	assign ram_raddr = (state_q == S_IDLE) ? count_m1[ADDR_W-1:0] : scan_raddr;

	dss_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (scan_cmd),
		.rdata  (ram_rdata),
		.raddr  (scan_raddr),
		.stat   (scan_stat)
	);

	dss_ram #(
		.Width (VALUE_W),
		.Depth (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (res_q.popped_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		res_d = res_q;
		unique case (state_q)
			S_IDLE: begin
				res_d = '0;
				res_d.popped_value = (req.func == FUNC_ADD) ? req.item_value : '0;
				res_d.entry_count = COUNT_OUT_W'(count_q);
				res_d.is_empty = (count_q == '0);
			end
			S_SCAN: begin
				res_d.popped_value = '0;
				res_d.found = scan_stat.hit;
				if ((func_q == FUNC_ADD) && !scan_stat.hit) begin
					res_d.full_refused = full;
					res_d.stored = !full;
					if (!full) begin
						res_d.entry_count = COUNT_OUT_W'(count_inc);
						res_d.is_empty = 1'b0;
					end
				end
			end
			S_POPRD: begin
				res_d.popped_valid = 1'b1;
				res_d.popped_value = ram_rdata;
				res_d.entry_count = COUNT_OUT_W'(count_m1);
				res_d.is_empty = (count_m1 == '0);
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q <= FUNC_ADD;
			count_q <= '0;
			res_q <= '0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= req.func;
						res_q <= res_d;
						unique case (req.func)
							FUNC_ADD, FUNC_CONTAINS: state_q <= S_SCAN;
							FUNC_POP: state_q <= (count_q != '0) ? S_POPRD : S_DONE;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_stat.done) begin
						state_q <= S_DONE;
						res_q <= res_d;
						if (ram_we) begin
							count_q <= count_inc;
						end
					end
				end
				S_POPRD: begin
					state_q <= S_DONE;
					count_q <= count_m1;
					res_q <= res_d;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTH
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stat.done |-> (state_q == S_SCAN))
		else $error("scan finished outside a lookup");

	a_pop_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.func == FUNC_POP) && (count_q != '0)) |=>
		##1 (count_q == $past(count_m1, 2)))
		else $error("pop did not remove one entry");

	a_stored_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.stored) |-> !rsp.is_empty)
		else $error("stored result reports an empty set");
`endif

endmodule

### design/dss_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dss_ram #(
	parameter int Width = 64,
	parameter int Depth = 16,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/dss_scan.sv
// ----------------------------------------------------------------------------
// Set store scan engine
// Walks the entries in use one address per cycle through the store's read
// port and compares each with the key in a single 64-bit comparator.
// ----------------------------------------------------------------------------
module dss_scan
	import dss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  scan_cmd_t          cmd,
	input  logic [VALUE_W-1:0] rdata,
	output logic [ADDR_W-1:0]  raddr,
	output scan_stat_t         stat
);

	logic               active_q;
	logic               pend_s1;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   limit_q;
	logic [VALUE_W-1:0] key_q;
	scan_stat_t         stat_q;
	logic               hit_now;
	logic               issue;
	logic               finish;

	assign hit_now = pend_s1 && (rdata == key_q);
	assign issue = active_q && !hit_now && (idx_q < limit_q);
	assign finish = active_q && (hit_now || !issue);
	assign raddr = idx_q[ADDR_W-1:0];
	assign stat = stat_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			limit_q <= cmd.limit;
			key_q <= cmd.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pend_s1 <= 1'b0;
			idx_q <= '0;
			stat_q <= '0;
		end else begin
			stat_q <= '{done: finish && !cmd.start, hit: finish && !cmd.start && hit_now};
			if (cmd.start) begin
				active_q <= 1'b1;
				pend_s1 <= 1'b0;
				idx_q <= '0;
			end else if (active_q) begin
				pend_s1 <= issue;
				idx_q <= idx_q + CNT_W'(issue);
				if (finish) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

### tb/tb_dedup_set_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deduplicating set store testbench
// Drives add, contains, pop and unused requests through the valid/ready
// request channel, predicts every result from a private copy of the set and
// compares each result transfer field by field, with random idling on both
// channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_dedup_set_store;
	import dss_pkg::*;

	localparam int POOL_SIZE = 24;
	localparam int STALL_CYCLES = 150;
	localparam int MAX_SHOWN = 30;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	logic [VALUE_W-1:0] set_entries [CAPACITY];
	int set_count;
	rsp_t pending_responses[$];
	logic [VALUE_W-1:0] value_pool [POOL_SIZE];

	bit tx_idle_on;
	bit rx_idle_on;
	bit stall_request;
	int stall_left;

	int mismatches;
	int requests_sent;
	int results_checked;
	int adds_stored;
	int hits_seen;
	int adds_refused;
	int pops_returned;

	dedup_set_store uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	function automatic rsp_t predict_set_response(req_t r);
		rsp_t o;
		bit hit;
		o = '0;
		hit = 1'b0;
		for (int i = 0; i < set_count; i++) begin
			if (set_entries[i] == r.item_value)
				hit = 1'b1;
		end
		case (r.func)
			FUNC_ADD: begin
				if (hit) begin
					o.found = 1'b1;
				end else if (set_count >= CAPACITY) begin
					o.full_refused = 1'b1;
				end else begin
					set_entries[set_count] = r.item_value;
					set_count++;
					o.stored = 1'b1;
				end
			end
			FUNC_CONTAINS: begin
				o.found = hit;
			end
			FUNC_POP: begin
				if (set_count > 0) begin
					set_count--;
					o.popped_value = set_entries[set_count];
					o.popped_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
		o.entry_count = COUNT_OUT_W'(set_count);
		o.is_empty = (set_count == 0);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < MAX_SHOWN)
			$display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// Called at a rising edge; returns at the edge where the transfer happens.
	task automatic send_item(input logic [1:0] f, input logic [VALUE_W-1:0] v);
		req_t r;
		rsp_t want;
		r.func = f;
		r.item_value = v;
		if (tx_idle_on && $urandom_range(99) < 21) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		want = predict_set_response(r);
		pending_responses.push_back(want);
		requests_sent++;
		adds_stored += int'(want.stored);
		hits_seen += int'(want.found);
		adds_refused += int'(want.full_refused);
		pops_returned += int'(want.popped_valid);
	endtask

	task automatic wait_for_drain(input int limit);
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		while (pending_responses.size() != 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
		repeat (CAPACITY + 4) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55)
			return value_pool[$urandom_range(POOL_SIZE - 1)];
		if (sel < 75 && set_count > 0)
			return set_entries[$urandom_range(set_count - 1)];
		return {$urandom, $urandom};
	endfunction

	task automatic send_random(input bit filling);
		int roll;
		int add_share;
		roll = $urandom_range(99);
		add_share = filling ? 60 : 20;
		if (roll < add_share)
			send_item(FUNC_ADD, pick_value());
		else if (roll < add_share + 20)
			send_item(FUNC_CONTAINS, pick_value());
		else if (roll < add_share + 24)
			send_item(FUNC_UNUSED, {$urandom, $urandom});
		else
			send_item(FUNC_POP, {$urandom, $urandom});
	endtask

	task automatic test_empty_set();
		send_item(FUNC_POP, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(FUNC_CONTAINS, 64'h0);
		send_item(FUNC_UNUSED, 64'h0);
		wait_for_drain(2000);
	endtask

	task automatic test_capacity_limit();
		send_item(FUNC_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(FUNC_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(FUNC_ADD, 64'h0);
		for (int i = 1; i < CAPACITY - 1; i++)
			send_item(FUNC_ADD, 64'h0123_4567_89AB_CDEF ^ (64'h1 << (i * 4)));
		send_item(FUNC_ADD, 64'h8000_0000_0000_0000);
		send_item(FUNC_ADD, 64'h0);
		send_item(FUNC_CONTAINS, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(FUNC_POP, 64'h0);
		send_item(FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		wait_for_drain(2000);
	endtask

	task automatic test_random_mix(input int n);
		for (int k = 0; k < n; k++)
			send_random(((k / 30) % 2) == 0);
		wait_for_drain(5000);
	endtask

	task automatic test_steady_stream(input int n);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int k = 0; k < n; k++)
			send_random(((k / 25) % 2) == 0);
		wait_for_drain(5000);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_output_stall(input int n);
		tx_idle_on = 1'b0;
		stall_request = 1'b1;
		for (int k = 0; k < n; k++)
			send_random(k < n / 2);
		wait_for_drain(5000);
		tx_idle_on = 1'b1;
	endtask

	// Receiver: random idling, plus a long hold-off when a test asks for one.
	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				stall_left = STALL_CYCLES;
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				rsp_ready <= !(rx_idle_on && $urandom_range(99) < 21);
			end
		end
	end

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("unexpected result", rsp.popped_value, 64'h0);
			end else begin
				want = pending_responses.pop_front();
				results_checked++;
				if (rsp.found !== want.found)
					report_mismatch("found", 64'(rsp.found), 64'(want.found));
				if (rsp.stored !== want.stored)
					report_mismatch("stored", 64'(rsp.stored), 64'(want.stored));
				if (rsp.full_refused !== want.full_refused)
					report_mismatch("full_refused", 64'(rsp.full_refused),
						64'(want.full_refused));
				if (rsp.popped_valid !== want.popped_valid)
					report_mismatch("popped_valid", 64'(rsp.popped_valid),
						64'(want.popped_valid));
				if (rsp.popped_value !== want.popped_value)
					report_mismatch("popped_value", rsp.popped_value, want.popped_value);
				if (rsp.entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(rsp.entry_count),
						64'(want.entry_count));
				if (rsp.is_empty !== want.is_empty)
					report_mismatch("is_empty", 64'(rsp.is_empty), 64'(want.is_empty));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Run timed out with %0d results outstanding.", pending_responses.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		set_count = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		stall_request = 1'b0;
		stall_left = 0;
		value_pool[0] = 64'h0;
		value_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
		value_pool[2] = 64'h1;
		value_pool[3] = 64'h8000_0000_0000_0000;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = {$urandom, $urandom};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_set();
		test_capacity_limit();
		test_random_mix(200);
		test_steady_stream(110);
		test_output_stall(40);
		test_random_mix(125);

		wait_for_drain(5000);
		if (pending_responses.size() != 0)
			report_mismatch("results never delivered", 64'(pending_responses.size()), 64'h0);
		$display("Sent %0d requests: %0d adds stored, %0d hits, %0d refused when full, %0d pops.",
			requests_sent, adds_stored, hits_seen, adds_refused, pops_returned);
		$display("Checked %0d results with %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
design/dss_pkg.sv
design/dss_ram.sv
design/dss_scan.sv
design/dedup_set_store.sv
tb/tb_dedup_set_store.sv
